### sv/mdpf_pkg.sv
// Shared constants and types for the match displacement percentile filter.
`timescale 1ns / 1ps

package mdpf_pkg;

    // Store geometry.
    localparam int MAX_PAIRS = 64;
    localparam int ADDR_W    = $clog2(MAX_PAIRS);
    localparam int CNT_W     = $clog2(MAX_PAIRS + 1);

    // Field widths.
    localparam int COORD_W = 16;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;

    // Rank floor(4N/5) is taken as (N * RANK_MUL) >> RANK_SHIFT, exact for N <= 64.
    localparam int RANK_SHIFT = 10;
    localparam int RANK_MUL   = (4 * (1 << RANK_SHIFT) + 4) / 5;
    localparam int RANK_PW    = CNT_W + RANK_SHIFT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_STORE,
        ST_CAND,
        ST_CLATCH,
        ST_SWEEP,
        ST_CHECK,
        ST_EMIT
    } mdpf_state_t;

endpackage

### sv/match_displacement_percentile_filter_top.sv
// Top level of the match displacement percentile filter.
`timescale 1ns / 1ps

//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | left_x, left_y, right_x, right_y, last_pair
//  m_       | out       | pair_index, keep, threshold, last_result
//
// Each request's squared distance is stored through the diff, square and write steps.
// After the last pair, rank selection runs candidate by candidate: each candidate
// is read, then swept over the stored distances on the single read port of the
// distance memory and checked. Each result is then read before it is loaded out.
// Reset (aresetn low, synchronous) clears the pair count and the output valid.
// A stalled result channel holds the emit sequence; s_ready is low while a pair is
// squared and stored, and from the last pair until the final result is loaded.

module match_displacement_percentile_filter_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mdpf_pkg::COORD_W-1:0] s_left_x,
    input  logic [mdpf_pkg::COORD_W-1:0] s_left_y,
    input  logic [mdpf_pkg::COORD_W-1:0] s_right_x,
    input  logic [mdpf_pkg::COORD_W-1:0] s_right_y,
    input  logic                         s_last_pair,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mdpf_pkg::ADDR_W-1:0]  m_pair_index,
    output logic                         m_keep,
    output logic [mdpf_pkg::DIST_W-1:0]  m_threshold,
    output logic                         m_last_result
);
    import mdpf_pkg::*;

    // Distance memory.
    logic [DIST_W-1:0] dist_mem [MAX_PAIRS];
    logic [DIST_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;

    // Control and datapath registers.
    mdpf_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              last_reg, last_next;
    logic [COORD_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [SQ_W-1:0]   sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [ADDR_W-1:0] cand_reg, cand_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [ADDR_W-1:0] emit_reg, emit_next;
    logic [DIST_W-1:0] cand_val_reg, cand_val_next;
    logic [DIST_W-1:0] thr_reg, thr_next;
    logic [CNT_W-1:0]  less_reg, less_next, same_reg, same_next;

    // Output registers.
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_index_reg, m_index_next;
    logic              m_keep_reg, m_keep_next;
    logic [DIST_W-1:0] m_thr_reg, m_thr_next;
    logic              m_last_reg, m_last_next;

    // Derived values.
    logic [CNT_W-1:0]   n_m1;
    logic [RANK_PW-1:0] rank_prod;
    logic [CNT_W-1:0]   rank;
    logic [CNT_W:0]     less_same;
    logic               store_full;

    assign n_m1       = count_reg - CNT_W'(1);
    assign rank_prod  = RANK_PW'(count_reg) * RANK_PW'(RANK_MUL);
    assign rank       = rank_prod[RANK_PW-1:RANK_SHIFT];
    assign less_same  = {1'b0, less_reg} + {1'b0, same_reg};
    assign store_full = (count_reg == CNT_W'(MAX_PAIRS));

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_pair_index  = m_index_reg;
    assign m_keep        = m_keep_reg;
    assign m_threshold   = m_thr_reg;
    assign m_last_result = m_last_reg;

    // Memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dist_mem[count_reg[ADDR_W-1:0]] <= DIST_W'({1'b0, sqx_reg} + {1'b0, sqy_reg});
        end
        rd_data_reg <= dist_mem[rd_addr];
    end

    // Next state, datapath and read address.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        sqx_next      = sqx_reg;
        sqy_next      = sqy_reg;
        cand_next     = cand_reg;
        sweep_next    = sweep_reg;
        emit_next     = emit_reg;
        cand_val_next = cand_val_reg;
        thr_next      = thr_reg;
        less_next     = less_reg;
        same_next     = same_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_index_next  = m_index_reg;
        m_keep_next   = m_keep_reg;
        m_thr_next    = m_thr_reg;
        m_last_next   = m_last_reg;
        rd_addr       = cand_reg;
        mem_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dx_next    = (s_left_x >= s_right_x) ? s_left_x - s_right_x
                                                         : s_right_x - s_left_x;
                    dy_next    = (s_left_y >= s_right_y) ? s_left_y - s_right_y
                                                         : s_right_y - s_left_y;
                    last_next  = s_last_pair;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                sqx_next   = dx_reg * dx_reg;
                sqy_next   = dy_reg * dy_reg;
                state_next = ST_STORE;
            end
            ST_STORE: begin
                // A pair that arrives with the store full is dropped.
                if (!store_full) begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                cand_next  = '0;
                state_next = last_reg ? ST_CAND : ST_IDLE;
            end
            ST_CAND: begin
                rd_addr    = cand_reg;
                state_next = ST_CLATCH;
            end
            ST_CLATCH: begin
                cand_val_next = rd_data_reg;
                rd_addr       = '0;
                sweep_next    = '0;
                less_next     = '0;
                same_next     = '0;
                state_next    = ST_SWEEP;
            end
            ST_SWEEP: begin
                // Count stored distances below and equal to the candidate.
                rd_addr = sweep_reg + ADDR_W'(1);
                if (rd_data_reg < cand_val_reg) begin
                    less_next = less_reg + CNT_W'(1);
                end else if (rd_data_reg == cand_val_reg) begin
                    same_next = same_reg + CNT_W'(1);
                end
                if (sweep_reg == n_m1[ADDR_W-1:0]) begin
                    state_next = ST_CHECK;
                end else begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            ST_CHECK: begin
                if ((less_reg <= rank) && ({1'b0, rank} < less_same)) begin
                    thr_next   = cand_val_reg;
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    cand_next  = cand_reg + ADDR_W'(1);
                    state_next = ST_CAND;
                end
            end
            ST_EMIT: begin
                // Odd/even phase: read the entry, then load the output slot when it is free.
                rd_addr = emit_reg;
                if (!m_valid_reg && (sweep_reg == emit_reg)) begin
                    m_valid_next = 1'b1;
                    m_index_next = emit_reg;
                    m_keep_next  = (rd_data_reg < thr_reg);
                    m_thr_next   = thr_reg;
                    m_last_next  = (emit_reg == n_m1[ADDR_W-1:0]);
                    sweep_next   = emit_reg + ADDR_W'(1);
                    if (emit_reg == n_m1[ADDR_W-1:0]) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        emit_next = emit_reg + ADDR_W'(1);
                    end
                end else begin
                    // Read data for emit_reg is valid on the next cycle.
                    sweep_next = emit_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Register update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        last_reg     <= last_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        cand_reg     <= cand_next;
        sweep_reg    <= sweep_next;
        emit_reg     <= emit_next;
        cand_val_reg <= cand_val_next;
        thr_reg      <= thr_next;
        less_reg     <= less_next;
        same_reg     <= same_next;
        m_index_reg  <= m_index_next;
        m_keep_reg   <= m_keep_next;
        m_thr_reg    <= m_thr_next;
        m_last_reg   <= m_last_next;
    end

    // The pair count never passes the store depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PAIRS))
        else $error("pair count exceeds store depth");

    // Selection never runs past the stored pairs.
    a_cand_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> ({1'b0, cand_reg} < count_reg))
        else $error("rank candidate beyond stored pairs");

    // A sweep never counts more distances than are stored.
    a_sweep_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (less_same <= {1'b0, count_reg}))
        else $error("sweep counts exceed pair count");

    // A result is loaded only into an empty output slot.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(m_index_reg) && $stable(m_thr_reg)))
        else $error("pending result overwritten");

endmodule

### tb/match_displacement_percentile_filter_top_test.sv
// Testbench for the match displacement percentile filter: random and directed pair sets.
`timescale 1ns / 1ps

module match_displacement_percentile_filter_top_test;

    import mdpf_pkg::*;

    localparam int RANK_NUM         = 4;
    localparam int RANK_DEN         = 5;
    localparam int RESET_CYCLES     = 8;
    localparam int SINK_HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT      = 40000;
    localparam int END_SETTLE       = 200;
    localparam int RANDOM_PAIRS     = 280;

    // One verdict as the block reports it.
    typedef struct packed {
        bit [ADDR_W-1:0] idx;
        bit              keep;
        bit [DIST_W-1:0] thr;
        bit              last;
    } verdict_t;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [COORD_W-1:0] s_left_x      = '0;
    logic [COORD_W-1:0] s_left_y      = '0;
    logic [COORD_W-1:0] s_right_x     = '0;
    logic [COORD_W-1:0] s_right_y     = '0;
    logic               s_last_pair   = 1'b0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [ADDR_W-1:0]  m_pair_index;
    logic               m_keep;
    logic [DIST_W-1:0]  m_threshold;
    logic               m_last_result;

    // Predictor state: squared distances of the current set and how many are held.
    bit [DIST_W:0] sq_dist_mem [MAX_PAIRS];
    int            pair_total = 0;
    verdict_t      verdict_q [$];

    int fail_count    = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    bit sink_hold_req = 1'b0;

    match_displacement_percentile_filter_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_x      (s_left_x),
        .s_left_y      (s_left_y),
        .s_right_x     (s_right_x),
        .s_right_y     (s_right_y),
        .s_last_pair   (s_last_pair),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pair_index  (m_pair_index),
        .m_keep        (m_keep),
        .m_threshold   (m_threshold),
        .m_last_result (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Store one pair's squared distance; on the last pair, rank the set and queue verdicts.
    function automatic void predict_verdicts(input bit [COORD_W-1:0] lx, input bit [COORD_W-1:0] ly,
                                             input bit [COORD_W-1:0] rx, input bit [COORD_W-1:0] ry,
                                             input bit last);
        bit [DIST_W:0] dx;
        bit [DIST_W:0] dy;
        bit [DIST_W:0] ranked [MAX_PAIRS];
        bit [DIST_W:0] thr;
        bit [DIST_W:0] tmp;
        verdict_t      v;
        int            rank;
        int            i;
        int            j;
        dx = (lx >= rx) ? lx - rx : rx - lx;
        dy = (ly >= ry) ? ly - ry : ry - ly;
        if (pair_total < MAX_PAIRS) begin
            sq_dist_mem[pair_total] = dx * dx + dy * dy;
            pair_total++;
        end
        if (!last) return;
        // Insertion sort of the held distances, then pick the percentile rank.
        for (i = 0; i < pair_total; i++) begin
            tmp = sq_dist_mem[i];
            j = i;
            while (j > 0 && ranked[j - 1] > tmp) begin
                ranked[j] = ranked[j - 1];
                j--;
            end
            ranked[j] = tmp;
        end
        rank = (RANK_NUM * pair_total) / RANK_DEN;
        thr  = ranked[rank];
        for (i = 0; i < pair_total; i++) begin
            v.idx  = ADDR_W'(i);
            v.keep = (sq_dist_mem[i] < thr);
            v.thr  = thr[DIST_W-1:0];
            v.last = (i == pair_total - 1);
            verdict_q = {verdict_q, v};
        end
        pair_total = 0;
    endfunction

    // Idle length before the next request: mostly none or short, a few long.
    function automatic int pick_gap();
        if (tx_idle_pct == 0 || $urandom_range(99) >= tx_idle_pct) return 0;
        return ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Offer one pair and wait for it to be taken.
    task automatic send_pair(input bit [COORD_W-1:0] lx, input bit [COORD_W-1:0] ly,
                             input bit [COORD_W-1:0] rx, input bit [COORD_W-1:0] ry,
                             input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_left_x    <= lx;
        s_left_y    <= ly;
        s_right_x   <= rx;
        s_right_y   <= ry;
        s_last_pair <= last;
        do @(posedge aclk); while (!s_ready);
        predict_verdicts(lx, ly, rx, ry, last);
    endtask

    // Stop offering and wait until every expected verdict has come back.
    task automatic wait_for_verdicts();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdict_q.size() != 0);
    endtask

    // One set of random pairs, mixing wide, close, duplicated and extreme displacements.
    task automatic send_random_set(input int n_pairs);
        bit [COORD_W-1:0] lx;
        bit [COORD_W-1:0] ly;
        bit [COORD_W-1:0] rx;
        bit [COORD_W-1:0] ry;
        int               i;
        int               style;
        for (i = 0; i < n_pairs; i++) begin
            style = $urandom_range(7);
            lx = COORD_W'($urandom);
            ly = COORD_W'($urandom);
            rx = COORD_W'($urandom);
            ry = COORD_W'($urandom);
            case (style)
                3, 4: begin
                    rx = lx + COORD_W'($urandom_range(31)) - 16'd16;
                    ry = ly + COORD_W'($urandom_range(31)) - 16'd16;
                end
                5: begin
                    rx = lx + COORD_W'($urandom_range(2));
                    ry = ly + COORD_W'($urandom_range(2));
                end
                6: begin
                    lx = $urandom_range(1) ? '1 : '0;
                    ly = $urandom_range(1) ? '1 : '0;
                    rx = $urandom_range(1) ? '1 : '0;
                    ry = $urandom_range(1) ? '1 : '0;
                end
                7: begin
                    rx = lx;
                    ry = ly;
                end
                default: begin
                end
            endcase
            send_pair(lx, ly, rx, ry, i == n_pairs - 1);
        end
    endtask

    // Zero and full-scale coordinates, including the largest possible distance.
    task automatic test_extremes();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
        send_pair(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        send_pair(16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_pair(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b1);
        wait_for_verdicts();
    endtask

    // A set of one pair: the threshold is its own distance and nothing is kept.
    task automatic test_single_pair();
        send_pair(16'h1234, 16'h5678, 16'h1000, 16'h2000, 1'b1);
        wait_for_verdicts();
        send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        wait_for_verdicts();
    endtask

    // Ties: every distance equal, then a set with repeated values around the rank.
    task automatic test_equal_distances();
        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        send_pair(16'd0, 16'd0, 16'd3, 16'd4, 1'b0);
        send_pair(16'd4, 16'd3, 16'd0, 16'd0, 1'b0);
        send_pair(16'd5, 16'd9, 16'd0, 16'd9, 1'b0);
        send_pair(16'd7, 16'd0, 16'd7, 16'd5, 1'b0);
        send_pair(16'd10, 16'd10, 16'd13, 16'd14, 1'b1);
        wait_for_verdicts();
        send_pair(16'd50, 16'd50, 16'd50, 16'd50, 1'b0);
        send_pair(16'd9, 16'd8, 16'd9, 16'd8, 1'b0);
        send_pair(16'd1, 16'd0, 16'd0, 16'd0, 1'b0);
        send_pair(16'd0, 16'd1, 16'd0, 16'd0, 1'b0);
        send_pair(16'd0, 16'd0, 16'd0, 16'd1, 1'b0);
        send_pair(16'd2, 16'd0, 16'd0, 16'd0, 1'b1);
        wait_for_verdicts();
    endtask

    // A full store, and a set that runs past it with the pairs beyond the store discarded.
    task automatic test_store_overflow();
        tx_idle_pct  = 15;
        rx_stall_pct = 15;
        send_random_set(MAX_PAIRS);
        wait_for_verdicts();
        send_random_set(MAX_PAIRS + 3);
        wait_for_verdicts();
    endtask

    // Results held off for a long stretch while the sender keeps offering sets.
    task automatic test_result_backpressure();
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        sink_hold_req = 1'b1;
        send_random_set(5);
        send_random_set(4);
        send_random_set(6);
        wait_for_verdicts();
    endtask

    // The sender pauses until the whole set has been reported, then goes on.
    task automatic test_pause_until_drained();
        tx_idle_pct  = 20;
        rx_stall_pct = 40;
        send_random_set(7);
        wait_for_verdicts();
        send_random_set(3);
        wait_for_verdicts();
    endtask

    // Random sets of mostly small sizes, with the idle rates changing from set to set.
    task automatic test_random_sets();
        int sent;
        int n_pairs;
        int r;
        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            r = $urandom_range(99);
            if (r < 70)      n_pairs = $urandom_range(1, 12);
            else if (r < 92) n_pairs = $urandom_range(13, 40);
            else             n_pairs = $urandom_range(41, MAX_PAIRS);
            r = $urandom_range(3);
            tx_idle_pct  = (r == 0) ? 0 : (r == 1) ? 15 : 50;
            r = $urandom_range(3);
            rx_stall_pct = (r == 0) ? 0 : (r == 1) ? 15 : 50;
            send_random_set(n_pairs);
            sent += n_pairs;
            if ($urandom_range(3) == 0) wait_for_verdicts();
        end
        wait_for_verdicts();
    endtask

    // Result side: random ready, with occasional long holds and one forced long hold.
    initial begin : result_sink
        int hold;
        forever begin
            @(posedge aclk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(posedge aclk);
            end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
                hold = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (hold - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expected verdict.
    always @(posedge aclk) begin : verdict_checker
        verdict_t due;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("pair_index: no result expected, actual %0d", m_pair_index);
                fail_count++;
            end else begin
                due = verdict_q.pop_front();
                if (m_pair_index !== due.idx) begin
                    $error("pair_index: expected %0d, actual %0d", due.idx, m_pair_index);
                    fail_count++;
                end
                if (m_keep !== due.keep) begin
                    $error("keep: expected %0d, actual %0d", due.keep, m_keep);
                    fail_count++;
                end
                if (m_threshold !== due.thr) begin
                    $error("threshold: expected %0d, actual %0d", due.thr, m_threshold);
                    fail_count++;
                end
                if (m_last_result !== due.last) begin
                    $error("last_result: expected %0d, actual %0d", due.last, m_last_result);
                    fail_count++;
                end
            end
        end
    end

    // End the run if neither channel moves a request for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : test_sequence
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_single_pair();
        test_equal_distances();
        test_store_overflow();
        test_result_backpressure();
        test_pause_until_drained();
        test_random_sets();
        wait_for_verdicts();
        repeat (END_SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
